@@ rtl/core/bsft_pkg.sv @@
// ----------------------------------------------------------------------------
// bsft_pkg
// Shared constants, types and the CRC-16/X.25 byte update for the framer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsft_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    // entries held between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // one classified request: payload byte, end-of-frame mark, and the
    // complemented CRC that closes the frame (meaningful only when last)
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_last;
        logic [15:0] fcs;
    } entry_t;

    // reflected CRC, eight shifts per byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bsft_in_if.sv @@
// ----------------------------------------------------------------------------
// bsft_in_if
// Payload byte channel: valid/ready handshake with byte and last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsft_out_if.sv @@
// ----------------------------------------------------------------------------
// bsft_out_if
// Line byte channel: valid/ready handshake with line byte and run end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsft_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       run_last;

    modport source (output valid, output line_byte, output run_last, input ready);
    modport sink   (input valid, input line_byte, input run_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/byte_stuffed_frame_transmitter_core.sv @@
// After a payload request is accepted, its first line byte passes the entry queue
// register, then the output register.
// Throughput: one line byte per cycle from the output sequencer while the line is
// ready; a request yields 1 line byte (plain), 2 (escaped) or 4 to 7 (last, with CRC and flag).
// Payload requests are taken back to back while the entry queue has room.
// Reset: asynchronous, active low; queue empties, CRC returns to 0xFFFF.
// ----------------------------------------------------------------------------
// byte_stuffed_frame_transmitter_core
// Byte-stuffing framer with CRC-16/X.25 trailer and closing flag.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffed_frame_transmitter_core #(
    parameter int QUEUE_DEPTH = bsft_pkg::QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bsft_in_if.sink    payload,
    bsft_out_if.source line
);
    import bsft_pkg::*;

    entry_t push_entry;
    logic   push_valid;
    logic   push_ready;
    entry_t head;
    logic   head_valid;
    logic   pop;

    bsft_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    bsft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    bsft_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .line       (line)
    );

endmodule

`default_nettype wire

@@ rtl/core/bsft_front.sv @@
// ----------------------------------------------------------------------------
// bsft_front
// Accepts payload requests, runs the frame CRC and pushes classified entries.
// ----------------------------------------------------------------------------
`default_nettype none

module bsft_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    bsft_in_if.sink             payload,
    output bsft_pkg::entry_t    push_entry,
    output logic                push_valid,
    input  wire logic           push_ready
);
    import bsft_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_upd;
    logic        accept;

    assign payload.ready = push_ready;
    assign push_valid    = payload.valid;
    assign accept        = payload.valid && push_ready;

    always_comb
    begin
        crc_upd               = crc_update(crc_reg, payload.data_byte);
        push_entry.data_byte  = payload.data_byte;
        push_entry.frame_last = payload.frame_last;
        push_entry.fcs        = ~crc_upd;
        crc_next              = crc_reg;
        if (accept)
            crc_next = payload.frame_last ? CRC_INIT : crc_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/bsft_queue.sv @@
// ----------------------------------------------------------------------------
// bsft_queue
// Small register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bsft_queue #(
    parameter int DEPTH = bsft_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bsft_pkg::entry_t  push_entry,
    input  wire logic              push_valid,
    output logic                   push_ready,
    output bsft_pkg::entry_t       head,
    output logic                   head_valid,
    input  wire logic              pop
);
    import bsft_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    entry_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

@@ rtl/core/bsft_back.sv @@
// ----------------------------------------------------------------------------
// bsft_back
// Sequences each entry into stuffed line bytes, CRC trailer and closing flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bsft_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bsft_pkg::entry_t  head,
    input  wire logic              head_valid,
    output logic                   pop,
    bsft_out_if.source             line
);
    import bsft_pkg::*;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_FLAG
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic        busy_reg;
    entry_t      cur_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    entry_t      act;
    logic        act_valid;
    logic        step;
    logic [7:0]  sel_byte;
    logic [7:0]  emit_byte;
    logic        special;
    logic        done;

    assign act       = busy_reg ? cur_reg : head;
    assign act_valid = busy_reg || head_valid;
    assign step      = act_valid && (!valid_reg || line.ready);
    // head is consumed the first time the back works on it
    assign pop       = step && !busy_reg;

    assign line.valid     = valid_reg;
    assign line.line_byte = byte_reg;
    assign line.run_last  = last_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_DATA:   sel_byte = act.data_byte;
            PH_CRC_LO: sel_byte = act.fcs[7:0];
            PH_CRC_HI: sel_byte = act.fcs[15:8];
            PH_FLAG:   sel_byte = FLAG_BYTE;
            default:   sel_byte = FLAG_BYTE;
        endcase

        // the closing flag itself is never escaped
        special = ((sel_byte == FLAG_BYTE) || (sel_byte == ESC_BYTE)) &&
                  (phase_reg != PH_FLAG);

        if (esc_reg)
            emit_byte = sel_byte ^ ESC_XOR;
        else if (special)
            emit_byte = ESC_BYTE;
        else
            emit_byte = sel_byte;

        done       = 1'b0;
        esc_next   = 1'b0;
        phase_next = phase_reg;
        if (!esc_reg && special)
            esc_next = 1'b1;
        else
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    if (act.frame_last)
                        phase_next = PH_CRC_LO;
                    else
                    begin
                        done       = 1'b1;
                        phase_next = PH_DATA;
                    end
                end
                PH_CRC_LO: phase_next = PH_CRC_HI;
                PH_CRC_HI: phase_next = PH_FLAG;
                PH_FLAG:
                begin
                    done       = 1'b1;
                    phase_next = PH_DATA;
                end
                default:
                begin
                    done       = 1'b1;
                    phase_next = PH_DATA;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DATA;
            esc_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                esc_reg   <= esc_next;
                busy_reg  <= !done;
                valid_reg <= 1'b1;
                byte_reg  <= emit_byte;
                last_reg  <= done;
                if (!busy_reg)
                    cur_reg <= head;
            end
            else if (line.ready)
                valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire
